// ----- hw/rtl/fbc_pkg.sv -----
// Shared types and constants for the frustum box culling block.
// No dependencies; imported by every module of the block.

package fbc_pkg;

    localparam int COORD_W  = 32;
    localparam int COEF_W   = COORD_W + 1;
    localparam int PROD_W   = COEF_W + COORD_W;
    localparam int SUM_W    = PROD_W + 2;
    localparam int NUM_COLS = 4;
    localparam int PLANE_W  = 3;
    localparam int ROW_W    = 2;

    localparam logic [PLANE_W-1:0] LAST_PLANE = 3'd5;
    localparam logic [PLANE_W-1:0] FLUSH_LAST = 3'd1;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TEST = 1'b1;

    // tdata layout of an input item
    localparam int TD_ROW_IDX = 0;
    localparam int TD_ROW_X   = TD_ROW_IDX + ROW_W;
    localparam int TD_ROW_Y   = TD_ROW_X + COORD_W;
    localparam int TD_ROW_Z   = TD_ROW_Y + COORD_W;
    localparam int TD_ROW_W   = TD_ROW_Z + COORD_W;
    localparam int TD_MIN_X   = TD_ROW_W + COORD_W;
    localparam int TD_MIN_Y   = TD_MIN_X + COORD_W;
    localparam int TD_MIN_Z   = TD_MIN_Y + COORD_W;
    localparam int TD_MAX_X   = TD_MIN_Z + COORD_W;
    localparam int TD_MAX_Y   = TD_MAX_X + COORD_W;
    localparam int TD_MAX_Z   = TD_MAX_Y + COORD_W;
    localparam int S_TDATA_W  = 328;
    localparam int M_TDATA_W  = 8;

    typedef struct packed {
        logic               wr_row;
        logic               start;
        logic               issue;
        logic [PLANE_W-1:0] plane;
        logic               res_load;
    } fbc_cmd_t;

endpackage

// ----- hw/rtl/fbc_ctrl.sv -----
// Controller for the frustum box culling block: input handshake, plane
// sequencing and result register valid. Depends on fbc_pkg.

module fbc_ctrl import fbc_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  logic     func,
    output logic     m_tvalid,
    input  logic     m_tready,
    output fbc_cmd_t cmd
);

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FLUSH, ST_DONE} state_t;

    state_t             state_reg, state_next;
    logic [PLANE_W-1:0] cnt_reg, cnt_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic               accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        cmd.wr_row    = accept && (func == FUNC_LOAD);
        cmd.start     = accept && (func == FUNC_TEST);
        cmd.issue     = (state_reg == ST_RUN);
        cmd.plane     = cnt_reg;
        cmd.res_load  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                cnt_next = '0;
                if (cmd.start) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (cnt_reg == LAST_PLANE) begin
                    cnt_next   = '0;
                    state_next = ST_FLUSH;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_FLUSH: begin
                if (cnt_reg == FLUSH_LAST) begin
                    cnt_next   = '0;
                    state_next = ST_DONE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.res_load  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

// ----- hw/rtl/fbc_datapath.sv -----
// Datapath for the frustum box culling block: matrix store, plane
// formation, vertex pick, products, distance sign. Depends on fbc_pkg.

module fbc_datapath import fbc_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  fbc_cmd_t                  cmd,
    input  logic [ROW_W-1:0]          row_index,
    input  logic signed [COORD_W-1:0] row_x,
    input  logic signed [COORD_W-1:0] row_y,
    input  logic signed [COORD_W-1:0] row_z,
    input  logic signed [COORD_W-1:0] row_w,
    input  logic signed [COORD_W-1:0] min_x,
    input  logic signed [COORD_W-1:0] min_y,
    input  logic signed [COORD_W-1:0] min_z,
    input  logic signed [COORD_W-1:0] max_x,
    input  logic signed [COORD_W-1:0] max_y,
    input  logic signed [COORD_W-1:0] max_z,
    output logic                      inside_res
);

    logic signed [COORD_W-1:0] mat_reg [NUM_COLS][NUM_COLS];
    logic signed [COORD_W-1:0] bmin_reg [3];
    logic signed [COORD_W-1:0] bmax_reg [3];

    logic signed [COEF_W-1:0]  coef_next [NUM_COLS];
    logic signed [COORD_W-1:0] vert_next [3];
    logic signed [COEF_W-1:0]  coef_reg [NUM_COLS];
    logic signed [COORD_W-1:0] vert_reg [3];
    logic signed [PROD_W-1:0]  prod_reg [3];
    logic signed [COEF_W-1:0]  dcoef_reg;
    logic                      v1_reg, v2_reg;
    logic                      inside_reg, res_reg;
    logic signed [SUM_W-1:0]   plane_sum;
    logic [ROW_W-1:0]          prow;
    logic                      plus;

    assign prow = cmd.plane[PLANE_W-1:1];
    assign plus = !cmd.plane[0];

    always_comb begin
        for (int k = 0; k < NUM_COLS; k++) begin
            if (plus) begin
                coef_next[k] = COEF_W'(mat_reg[3][k]) + COEF_W'(mat_reg[prow][k]);
            end else begin
                coef_next[k] = COEF_W'(mat_reg[3][k]) - COEF_W'(mat_reg[prow][k]);
            end
        end
        for (int k = 0; k < 3; k++) begin
            vert_next[k] = coef_next[k][COEF_W-1] ? bmin_reg[k] : bmax_reg[k];
        end
    end

    assign plane_sum = SUM_W'(prod_reg[0]) + SUM_W'(prod_reg[1]) + SUM_W'(prod_reg[2])
                     + (SUM_W'(dcoef_reg) <<< FRAC_BITS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < NUM_COLS; r++) begin
                for (int k = 0; k < NUM_COLS; k++) begin
                    mat_reg[r][k] <= '0;
                end
            end
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            inside_reg <= 1'b1;
        end else begin
            if (cmd.wr_row) begin
                mat_reg[row_index][0] <= row_x;
                mat_reg[row_index][1] <= row_y;
                mat_reg[row_index][2] <= row_z;
                mat_reg[row_index][3] <= row_w;
            end
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            if (cmd.start) begin
                inside_reg <= 1'b1;
            end else if (v2_reg && plane_sum[SUM_W-1]) begin
                inside_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            bmin_reg[0] <= min_x;
            bmin_reg[1] <= min_y;
            bmin_reg[2] <= min_z;
            bmax_reg[0] <= max_x;
            bmax_reg[1] <= max_y;
            bmax_reg[2] <= max_z;
        end
        coef_reg <= coef_next;
        vert_reg <= vert_next;
        for (int k = 0; k < 3; k++) begin
            prod_reg[k] <= PROD_W'(coef_reg[k]) * PROD_W'(vert_reg[k]);
        end
        dcoef_reg <= coef_reg[3];
        if (cmd.res_load) begin
            res_reg <= inside_reg;
        end
    end

    assign inside_res = res_reg;

endmodule

// ----- hw/rtl/frustum_box_cull.sv -----
// Top level of the frustum box culling block.
// Depends on fbc_pkg, fbc_ctrl and fbc_datapath.

// A load item (s_tuser = 0) writes one row of the 4x4 view-projection matrix
// and is taken with no result. A test item (s_tuser = 1) checks an
// axis-aligned box against the six frustum planes, one plane per cycle
// through three shared multipliers feeding a two-stage pipeline; loading
// its result waits for any previous result still held on the master side.
// m_tdata[0] is 1 when the box is not behind any plane. Matrix entries reset
// to zero.

module frustum_box_cull import fbc_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // row_index, row_x, row_y, row_z, row_w, min_x, min_y, min_z, max_x, max_y, max_z
    input  logic [S_TDATA_W-1:0] s_tdata,
    // func
    input  logic [0:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // inside_res
    output logic [M_TDATA_W-1:0] m_tdata
);

    fbc_cmd_t cmd;
    logic     inside_res;

    fbc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .func     (s_tuser[0]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    fbc_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .row_index  (s_tdata[TD_ROW_IDX +: ROW_W]),
        .row_x      (s_tdata[TD_ROW_X +: COORD_W]),
        .row_y      (s_tdata[TD_ROW_Y +: COORD_W]),
        .row_z      (s_tdata[TD_ROW_Z +: COORD_W]),
        .row_w      (s_tdata[TD_ROW_W +: COORD_W]),
        .min_x      (s_tdata[TD_MIN_X +: COORD_W]),
        .min_y      (s_tdata[TD_MIN_Y +: COORD_W]),
        .min_z      (s_tdata[TD_MIN_Z +: COORD_W]),
        .max_x      (s_tdata[TD_MAX_X +: COORD_W]),
        .max_y      (s_tdata[TD_MAX_Y +: COORD_W]),
        .max_z      (s_tdata[TD_MAX_Z +: COORD_W]),
        .inside_res (inside_res)
    );

    assign m_tdata = {{(M_TDATA_W-1){1'b0}}, inside_res};

endmodule
